### rtl/core/sfr_pkg.sv
package sfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 4;
    localparam int CMD_BYTES   = 8;
    localparam int POS_W       = $clog2(CMD_BYTES);
    localparam int WORD_W      = CMD_BYTES * BYTE_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_BYTES  = 3'd0,
        CFG_NEEDLE_LENGTH = 3'd1,
        CFG_REPL_BYTES    = 3'd2,
        CFG_REPL_LENGTH   = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic              last;
        logic [LEN_W-1:0]  count;
        logic [WORD_W-1:0] bytes;
    } t_cmd;

endpackage

### rtl/core/stream_find_replace_core.sv
// Channel   Handshake          Payload
// input     i_valid / o_stall  i_in_byte, i_in_last
// output    o_valid / i_stall  o_out_byte, o_out_valid, o_out_last
// config    i_cfg_we           i_cfg_index, i_cfg_data
//
// One input byte per cycle while o_stall is low; the window compare runs in parallel in the front part.
// Each item yields 0 to 8 results, one per cycle from the back part's output register while i_stall is low.
// A four-entry command queue between the parts absorbs replacement bursts.
// Synchronous active-low reset clears the window fill, queue and output valid.
// o_stall rises only while the command queue is full.
module stream_find_replace_core
    import sfr_pkg::*;
#(
    parameter int MAX_NEEDLE_LEN  = 8,
    parameter int MAX_REPLACE_LEN = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [BYTE_W-1:0]     i_in_byte,
    input  logic                  i_in_last,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [BYTE_W-1:0]     o_out_byte,
    output logic                  o_out_valid,
    output logic                  o_out_last
);

    t_cfg_wr cfg;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    logic    push;
    logic    pop;
    logic    full;
    logic    nempty;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;
    assign o_stall   = full;

    sfr_front #(
        .MAX_NEEDLE_LEN  (MAX_NEEDLE_LEN),
        .MAX_REPLACE_LEN (MAX_REPLACE_LEN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .i_byte  (i_in_byte),
        .i_last  (i_in_last),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    sfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_full   (full),
        .o_nempty (nempty),
        .o_cmd    (head_cmd)
    );

    sfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nempty    (nempty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_out_valid (o_out_valid),
        .o_out_last  (o_out_last)
    );

endmodule

### rtl/core/sfr_front.sv
module sfr_front
    import sfr_pkg::*;
#(
    parameter int MAX_NEEDLE_LEN  = 8,
    parameter int MAX_REPLACE_LEN = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg_wr           i_cfg,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  logic              i_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    localparam int N = MAX_NEEDLE_LEN;

    logic [BYTE_W-1:0] r_win [N];
    logic [LEN_W-1:0]  r_fill;
    logic [WORD_W-1:0] r_needle;
    logic [LEN_W-1:0]  r_nlen;
    logic [WORD_W-1:0] r_repl;
    logic [LEN_W-1:0]  r_rlen;

    logic [BYTE_W-1:0] cand [N];
    logic [BYTE_W-1:0] n_win [N];
    logic [LEN_W-1:0]  n_fill;
    logic [N-1:0]      match;
    logic [LEN_W-1:0]  nlen_eff;
    logic [LEN_W-1:0]  rlen_eff;
    logic [LEN_W-1:0]  f1;
    logic [LEN_W-1:0]  e;
    logic              full_match;
    logic              accept;
    logic              needle_wr;

    assign accept    = i_valid && !i_full;
    assign needle_wr = i_cfg.we &&
                       (i_cfg.index inside {CFG_NEEDLE_BYTES, CFG_NEEDLE_LENGTH});

    always_comb begin
        int p;
        int k;
        int j;
        int q;
        if (r_nlen == '0) begin
            nlen_eff = LEN_W'(1);
        end else if (r_nlen > LEN_W'(N)) begin
            nlen_eff = LEN_W'(N);
        end else begin
            nlen_eff = r_nlen;
        end
        rlen_eff = (r_rlen > LEN_W'(MAX_REPLACE_LEN)) ? LEN_W'(MAX_REPLACE_LEN) : r_rlen;
        f1 = r_fill + LEN_W'(1);

        for (p = 0; p < N; p++) begin
            cand[p] = (LEN_W'(p) < r_fill) ? r_win[p] : i_byte;
        end

        for (p = 0; p < N; p++) begin
            match[p] = 1'b1;
            for (k = 0; k < N - p; k++) begin
                if ((p + k) <= int'(r_fill) &&
                    cand[p+k] != r_needle[k*BYTE_W +: BYTE_W]) begin
                    match[p] = 1'b0;
                end
            end
        end

        e = f1;
        for (p = N - 1; p >= 0; p--) begin
            if (p <= int'(r_fill) && match[p]) begin
                e = LEN_W'(p);
            end
        end
        full_match = match[0] && (f1 == nlen_eff);

        for (j = 0; j < N; j++) begin
            n_win[j] = cand[j];
            for (q = 0; q < N; q++) begin
                if (q == int'(e) + j) begin
                    n_win[j] = cand[q];
                end
            end
        end

        o_cmd.last  = i_last;
        o_cmd.bytes = '0;
        if (full_match) begin
            o_cmd.bytes = r_repl;
            o_cmd.count = rlen_eff;
            n_fill      = '0;
        end else begin
            for (p = 0; p < N; p++) begin
                o_cmd.bytes[p*BYTE_W +: BYTE_W] = cand[p];
            end
            o_cmd.count = i_last ? f1 : e;
            n_fill      = i_last ? '0 : (f1 - e);
        end
        o_push = accept && (o_cmd.count != '0 || i_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_needle <= '0;
            r_nlen   <= LEN_W'(1);
            r_repl   <= '0;
            r_rlen   <= '0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.index)
                    CFG_NEEDLE_BYTES:  r_needle <= i_cfg.data;
                    CFG_NEEDLE_LENGTH: r_nlen   <= i_cfg.data[LEN_W-1:0];
                    CFG_REPL_BYTES:    r_repl   <= i_cfg.data;
                    CFG_REPL_LENGTH:   r_rlen   <= i_cfg.data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (needle_wr) begin
                r_fill <= '0;
            end else if (accept) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !needle_wr) begin
            r_win <= n_win;
        end
    end

endmodule

### rtl/core/sfr_queue.sv
module sfr_queue
    import sfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_nempty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full   = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_cmd    = r_mem[r_rd];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_nempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### rtl/core/sfr_back.sv
module sfr_back
    import sfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_nempty,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_valid,
    output logic              o_out_last
);

    logic [POS_W-1:0]  r_pos;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_out_valid;
    logic              r_last;

    logic [POS_W-1:0]  n_pos;
    logic              adv;
    logic              is_end;
    logic [BYTE_W-1:0] sel_byte;

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_last;

    always_comb begin
        adv      = !r_valid || !i_stall;
        is_end   = (i_cmd.count == '0) ||
                   ((LEN_W'(r_pos) + LEN_W'(1)) == i_cmd.count);
        sel_byte = (i_cmd.count == '0) ? '0 : i_cmd.bytes[{r_pos, 3'b000} +: BYTE_W];
        o_pop    = adv && i_nempty && is_end;
        n_pos    = r_pos;
        if (adv && i_nempty) begin
            n_pos = is_end ? '0 : (r_pos + POS_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (adv) begin
                r_valid <= i_nempty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_nempty) begin
            r_byte      <= sel_byte;
            r_out_valid <= (i_cmd.count != '0);
            r_last      <= i_cmd.last && is_end;
        end
    end

endmodule
